// ----- hdl/ctw_pkg.sv -----
// ----------------------------------------------------------------------------
// ctw_pkg
// shared widths, register indexes, sideband type and fixed-point helpers
// for the clip-to-window transform
// ----------------------------------------------------------------------------
package ctw_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_W   = 16;
    // divisor magnitude never exceeds 2^24 in either path
    localparam int MAG_W     = 25;
    // 2^32 / 1 needs 33 quotient bits, one bit per divider stage
    localparam int QUOT_W    = 33;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_BASE   = 3'd5;

    localparam logic [DATA_W-1:0] ROUND_HALF = 32'h0000_0800;
    localparam logic [DATA_W-1:0] ROUND_MASK = 32'hffff_f000;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'hffff;

    // payload that rides alongside the reciprocal divider
    typedef struct packed {
        logic                     big;
        logic signed [DATA_W-1:0] zs;
        logic signed [DATA_W-1:0] ys;
        logic signed [DATA_W-1:0] xs;
    } side_t;

    // 16.16 multiply, arithmetic shift right by 16, wrapped to 32 bits
    function automatic logic signed [DATA_W-1:0] mul_q16(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [2*DATA_W-1:0] p;
        begin
            p = a * b;
            return p[DATA_W+15:16];
        end
    endfunction

endpackage

// ----- hdl/clip_to_window_transform.sv -----
// ----------------------------------------------------------------------------
// clip_to_window_transform
// clip-space vertex to window x/y, 16-bit depth and scaled 1/w, 16.16 fixed
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  s_*       in   tvalid/tready       tdata: clip_x, clip_y, clip_z, clip_w
//  m_*       out  tvalid/tready       tdata: window_x, window_y, depth, inv_w
//  cfg_*     in   cfg_valid/ready     cfg_index, cfg_data (six 32-bit regs)
//
//  one beat per cycle sustained while the skid buffer is empty; most of the
//  pipeline is the reciprocal divider, one quotient bit per stage
//  rst_n clears valid bits, the skid flag and the viewport registers
//  the whole pipeline moves on one enable; a beat refused downstream parks
//  in a one-entry skid buffer and s_tready drops only while it is occupied
//
module clip_to_window_transform
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // clip_x [31:0], clip_y [63:32], clip_z [95:64], clip_w [127:96]
    input  logic [4*ctw_pkg::DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // window_x [31:0], window_y [63:32], window_depth [79:64],
    // inv_w_scaled [111:80]
    output logic [3*ctw_pkg::DATA_W+ctw_pkg::DEPTH_W-1:0] m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ctw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ctw_pkg::DATA_W-1:0]        cfg_data
);

    localparam int DW    = ctw_pkg::DATA_W;
    localparam int OUT_W = 3*ctw_pkg::DATA_W + ctw_pkg::DEPTH_W;

    // ---------------------------------------------------------------- config
    logic signed [DW-1:0] scale_x_reg, scale_y_reg, origin_x_reg, origin_y_reg;
    logic signed [DW-1:0] depth_factor_reg, depth_base_reg;

    // writes are always accepted: cfg_ready is tied high
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg      <= '0;
            scale_y_reg      <= '0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            depth_factor_reg <= '0;
            depth_base_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ctw_pkg::REG_SCALE_X:      scale_x_reg      <= cfg_data;
                ctw_pkg::REG_SCALE_Y:      scale_y_reg      <= cfg_data;
                ctw_pkg::REG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                ctw_pkg::REG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                ctw_pkg::REG_DEPTH_FACTOR: depth_factor_reg <= cfg_data;
                ctw_pkg::REG_DEPTH_BASE:   depth_base_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow
    logic en;
    logic skid_valid_reg;
    logic [OUT_W-1:0] skid_data_reg;

    // pipeline freezes only while the skid buffer holds a beat
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------------------------------------------------------- stage a
    // clamp to [-w, w-1], pick path, pre-shift for the large-w path
    function automatic logic signed [DW-1:0] clamp_w(
        input logic signed [DW-1:0] v,
        input logic signed [DW-1:0] w
    );
        logic signed [DW-1:0] negw;
        logic signed [DW-1:0] wm1;
        logic signed [DW-1:0] r;
        begin
            negw = -w;
            wm1  = w - 1;
            r    = (v < negw) ? negw : v;
            r    = (r >= w) ? wm1 : r;
            return r;
        end
    endfunction

    logic signed [DW-1:0] in_x, in_y, in_z, in_w;
    logic signed [DW-1:0] cx, cy, cz;
    logic                 large_next;

    assign in_x = s_tdata[DW-1:0];
    assign in_y = s_tdata[2*DW-1:DW];
    assign in_z = s_tdata[3*DW-1:2*DW];
    assign in_w = s_tdata[4*DW-1:3*DW];

    assign cx = clamp_w(in_x, in_w);
    assign cy = clamp_w(in_y, in_w);
    assign cz = clamp_w(in_z, in_w);
    // w >> 24 is neither 0 nor -1
    assign large_next = !((in_w[DW-1:24] == '0) || (in_w[DW-1:24] == '1));

    logic                 a_valid_reg;
    ctw_pkg::side_t       a_side_reg;
    logic signed [DW-1:0] a_div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg.big <= large_next;
            a_side_reg.xs  <= large_next ? (cx >>> 8) : cx;
            a_side_reg.ys  <= large_next ? (cy >>> 8) : cy;
            a_side_reg.zs  <= large_next ? (cz >>> 8) : cz;
            a_div_reg      <= large_next ? (in_w >>> 8) : in_w;
        end
    end

    // ---------------------------------------------------------------- stage b
    // sign and magnitude of the divisor
    logic                         b_valid_reg;
    ctw_pkg::side_t               b_side_reg;
    logic [ctw_pkg::MAG_W-1:0]    b_mag_reg;
    logic                         b_neg_reg;
    logic                         b_zero_reg;
    logic [DW-1:0]                abs_next;

    assign abs_next = a_div_reg[DW-1] ? (-a_div_reg) : a_div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_side_reg <= a_side_reg;
            b_mag_reg  <= abs_next[ctw_pkg::MAG_W-1:0];
            b_neg_reg  <= a_div_reg[DW-1];
            b_zero_reg <= (a_div_reg == '0);
        end
    end

    // ---------------------------------------------------------------- divider
    logic                          r_valid;
    logic [ctw_pkg::QUOT_W-1:0]    r_quot;
    logic                          r_neg;
    logic                          r_zero;
    ctw_pkg::side_t                r_side;

    ctw_recip u_recip
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_valid_reg),
        .in_mag    (b_mag_reg),
        .in_neg    (b_neg_reg),
        .in_zero   (b_zero_reg),
        .in_side   (b_side_reg),
        .out_valid (r_valid),
        .out_quot  (r_quot),
        .out_neg   (r_neg),
        .out_zero  (r_zero),
        .out_side  (r_side)
    );

    // ---------------------------------------------------------------- stage c
    // signed reciprocal, wrapped to 32 bits; zero divisor gives zero
    logic                 c_valid_reg;
    ctw_pkg::side_t       c_side_reg;
    logic signed [DW-1:0] c_inv_reg;
    logic signed [DW-1:0] inv_next;
    logic [DW-1:0]        quot_lo;

    assign quot_lo  = r_quot[DW-1:0];
    assign inv_next = r_zero ? '0 : (r_neg ? (-quot_lo) : quot_lo);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg <= r_side;
            c_inv_reg  <= inv_next;
        end
    end

    // ---------------------------------------------------------------- stage d
    // first multiply; large path forms depth_factor * inv for depth
    logic                 d_valid_reg;
    logic                 d_large_reg;
    logic signed [DW-1:0] d_zs_reg;
    logic signed [DW-1:0] d_tx_reg, d_ty_reg, d_tz_reg;
    logic [DW-1:0]        d_invs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_large_reg <= c_side_reg.big;
            d_zs_reg    <= c_side_reg.zs;
            d_tx_reg    <= ctw_pkg::mul_q16(c_side_reg.xs, c_inv_reg);
            d_ty_reg    <= ctw_pkg::mul_q16(c_side_reg.ys, c_inv_reg);
            d_tz_reg    <= ctw_pkg::mul_q16(
                               c_side_reg.big ? depth_factor_reg : c_side_reg.zs,
                               c_inv_reg);
            d_invs_reg  <= c_side_reg.big ? (c_inv_reg << 2) : (c_inv_reg << 10);
        end
    end

    // ---------------------------------------------------------------- stage e
    // second multiply by viewport scale, and depth by the other factor
    logic                 e_valid_reg;
    logic                 e_large_reg;
    logic signed [DW-1:0] e_ux_reg, e_uy_reg, e_uz_reg;
    logic [DW-1:0]        e_invs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_large_reg <= d_large_reg;
            e_ux_reg    <= ctw_pkg::mul_q16(d_tx_reg, scale_x_reg);
            e_uy_reg    <= ctw_pkg::mul_q16(d_ty_reg, scale_y_reg);
            e_uz_reg    <= ctw_pkg::mul_q16(d_tz_reg,
                               d_large_reg ? d_zs_reg : depth_factor_reg);
            e_invs_reg  <= d_invs_reg;
        end
    end

    // ---------------------------------------------------------------- stage f
    // origin and base offsets, rounding in the small-w path, depth clamp
    logic [DW-1:0]                wx_sum, wy_sum, wx_next, wy_next;
    logic signed [DW-1:0]         dz_sum;
    logic [ctw_pkg::DEPTH_W-1:0]  depth_next;

    assign wx_sum = e_ux_reg + origin_x_reg;
    assign wy_sum = e_uy_reg + origin_y_reg;
    assign dz_sum = e_uz_reg + depth_base_reg;
    assign wx_next = e_large_reg ? wx_sum
                                 : ((wx_sum + ctw_pkg::ROUND_HALF) & ctw_pkg::ROUND_MASK);
    assign wy_next = e_large_reg ? wy_sum
                                 : ((wy_sum + ctw_pkg::ROUND_HALF) & ctw_pkg::ROUND_MASK);

    always_comb
    begin
        if (dz_sum[DW-1])
            depth_next = '0;
        else if (dz_sum[DW-2:ctw_pkg::DEPTH_W] != '0)
            depth_next = ctw_pkg::DEPTH_MAX;
        else
            depth_next = dz_sum[ctw_pkg::DEPTH_W-1:0];
    end

    logic             f_valid_reg;
    logic             f_large_reg;
    logic [OUT_W-1:0] f_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_large_reg <= e_large_reg;
            f_data_reg  <= {e_invs_reg, depth_next, wy_next, wx_next};
        end
    end

    // ---------------------------------------------------------------- skid
    // a beat refused downstream while the pipeline moves is parked here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
                skid_valid_reg <= 1'b0;
        end
        else if (f_valid_reg && !m_tready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_data_reg <= f_data_reg;
        end
    end

    assign m_tvalid = skid_valid_reg || f_valid_reg;
    assign m_tdata  = skid_valid_reg ? skid_data_reg : f_data_reg;

`ifndef SYNTHESIS
    // skid fills only from a refused final-stage beat
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(f_valid_reg && !m_tready))
        else $error("skid filled without a refused beat");

    // frozen pipeline keeps its final beat while the skid drains
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(f_valid_reg) && $stable(f_data_reg))
        else $error("final stage moved while skid occupied");

    // zero divisor must give a zero reciprocal
    a_zero_inv: assert property (@(posedge clk) disable iff (!rst_n)
        (en && r_valid && r_zero) |=> (c_inv_reg == '0))
        else $error("reciprocal of zero is not zero");

    // small-w path scales 1/w by 1024 and rounds x to 0x1000
    a_small_path: assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid_reg && !f_large_reg) |->
            (f_data_reg[OUT_W-DW+9:OUT_W-DW] == '0) && (f_data_reg[11:0] == '0))
        else $error("small-w path result not aligned");
`endif

endmodule

// ----- hdl/ctw_recip.sv -----
// ----------------------------------------------------------------------------
// ctw_recip
// pipelined restoring divider giving 2^32 / mag, one quotient bit per stage
// ----------------------------------------------------------------------------
module ctw_recip
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [ctw_pkg::MAG_W-1:0]     in_mag,
    input  logic                          in_neg,
    input  logic                          in_zero,
    input  ctw_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic [ctw_pkg::QUOT_W-1:0]    out_quot,
    output logic                          out_neg,
    output logic                          out_zero,
    output ctw_pkg::side_t                out_side
);

    localparam int N     = ctw_pkg::QUOT_W;
    localparam int REM_W = ctw_pkg::MAG_W;

    logic [N-1:0]               vld_reg;
    logic [REM_W-1:0]           rem_reg  [N];
    logic [N-1:0]               quot_reg [N];
    logic [ctw_pkg::MAG_W-1:0]  mag_reg  [N];
    logic [N-1:0]               neg_reg;
    logic [N-1:0]               zero_reg;
    ctw_pkg::side_t             side_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        // dividend is a one followed by zeros
        localparam logic DBIT = (k == 0);

        logic                      v_in;
        logic [REM_W-1:0]          rem_in;
        logic [N-1:0]              quot_in;
        logic [ctw_pkg::MAG_W-1:0] mag_in;
        logic                      neg_in;
        logic                      zero_in;
        ctw_pkg::side_t            side_in;
        logic [REM_W:0]            sh;
        logic                      ge;
        logic [REM_W:0]            diff;
        logic [REM_W-1:0]          rem_next;
        logic [N-1:0]              quot_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign quot_in = '0;
            assign mag_in  = in_mag;
            assign neg_in  = in_neg;
            assign zero_in = in_zero;
            assign side_in = in_side;
        end
        else begin : g_rest
            assign v_in    = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign quot_in = quot_reg[k-1];
            assign mag_in  = mag_reg[k-1];
            assign neg_in  = neg_reg[k-1];
            assign zero_in = zero_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign sh        = {rem_in, DBIT};
        assign ge        = (sh >= {1'b0, mag_in});
        assign diff      = sh - {1'b0, mag_in};
        assign rem_next  = ge ? diff[REM_W-1:0] : sh[REM_W-1:0];
        assign quot_next = {quot_in[N-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                quot_reg[k] <= quot_next;
                mag_reg[k]  <= mag_in;
                neg_reg[k]  <= neg_in;
                zero_reg[k] <= zero_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_quot  = quot_reg[N-1];
    assign out_neg   = neg_reg[N-1];
    assign out_zero  = zero_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for clip_to_window_transform: every accepted vertex is
// run through a fixed-point model of the transform and the window beats are
// compared field by field, in order, against it. Several viewport settings
// are applied between drained phases, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    import ctw_pkg::*;

    // expected window beat and the model of the transform
    class vertex_scoreboard;
        typedef struct {
            logic signed [31:0] wx;
            logic signed [31:0] wy;
            logic [15:0]        depth;
            logic [31:0]        inv_w;
        } window_t;

        logic signed [31:0] scale_x, scale_y, origin_x, origin_y;
        logic signed [31:0] depth_factor, depth_base;
        window_t            window_q[$];
        int                 errors;

        function new();
            scale_x = 0; scale_y = 0; origin_x = 0; origin_y = 0;
            depth_factor = 0; depth_base = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
            case (idx)
                REG_SCALE_X:      scale_x = v;
                REG_SCALE_Y:      scale_y = v;
                REG_ORIGIN_X:     origin_x = v;
                REG_ORIGIN_Y:     origin_y = v;
                REG_DEPTH_FACTOR: depth_factor = v;
                REG_DEPTH_BASE:   depth_base = v;
                default: ;
            endcase
        endfunction

        // (a*b)>>16, arithmetic, low 32 bits kept
        function logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
            longint p;
            p = longint'(a) * longint'(b);
            p = p >>> 16;
            return p[31:0];
        endfunction

        // 2^32 / a truncated toward zero, 0 for a zero divisor
        function logic signed [31:0] qrecip(logic signed [31:0] a);
            longint q;
            if (a == 0)
                return 0;
            q = (longint'(1) <<< 32) / longint'(a);
            return q[31:0];
        endfunction

        // raise to -w first, then lower to w-1; the second test wins
        function logic signed [31:0] clamp_w(logic signed [31:0] v, logic signed [31:0] w);
            logic signed [31:0] negw, wm1;
            negw = -w;
            wm1  = w - 1;
            if (v < negw)
                v = negw;
            if (v >= w)
                v = wm1;
            return v;
        endfunction

        function void note_vertex(logic [4*DATA_W-1:0] d);
            logic signed [31:0] x, y, z, w, hi, inv, dz;
            window_t r;
            w  = d[127:96];
            x  = clamp_w(d[31:0], w);
            y  = clamp_w(d[63:32], w);
            z  = clamp_w(d[95:64], w);
            hi = w >>> 24;
            if (hi != 0 && hi != -1)
            begin
                // large |w|: divide by w>>8 with pre-shifted operands
                inv     = qrecip(w >>> 8);
                r.inv_w = inv << 2;
                r.wx    = qmul(qmul(x >>> 8, inv), scale_x) + origin_x;
                r.wy    = qmul(qmul(y >>> 8, inv), scale_y) + origin_y;
                dz      = qmul(z >>> 8, qmul(depth_factor, inv)) + depth_base;
            end
            else
            begin
                inv     = qrecip(w);
                r.inv_w = inv << 10;
                r.wx    = (qmul(qmul(x, inv), scale_x) + origin_x + ROUND_HALF) & ROUND_MASK;
                r.wy    = (qmul(qmul(y, inv), scale_y) + origin_y + ROUND_HALF) & ROUND_MASK;
                dz      = qmul(qmul(z, inv), depth_factor) + depth_base;
            end
            if (dz < 0)
                r.depth = 0;
            else if (dz > 32'sh0000_ffff)
                r.depth = DEPTH_MAX;
            else
                r.depth = dz[15:0];
            window_q.push_back(r);
        endfunction

        task report(string msg);
            $display("tb: mismatch: %s", msg);
            errors++;
        endtask

        task check_window(logic [3*DATA_W+DEPTH_W-1:0] d);
            window_t e;
            if (window_q.size() == 0)
            begin
                report($sformatf("unexpected beat %h", d));
                return;
            end
            e = window_q.pop_front();
            if (d[31:0] !== e.wx)
                report($sformatf("window_x %h, want %h", d[31:0], e.wx));
            if (d[63:32] !== e.wy)
                report($sformatf("window_y %h, want %h", d[63:32], e.wy));
            if (d[79:64] !== e.depth)
                report($sformatf("window_depth %h, want %h", d[79:64], e.depth));
            if (d[111:80] !== e.inv_w)
                report($sformatf("inv_w_scaled %h, want %h", d[111:80], e.inv_w));
        endtask
    endclass

    localparam int WATCHDOG_LIMIT = 3000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [4*DATA_W-1:0]           s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [3*DATA_W+DEPTH_W-1:0]   m_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [DATA_W-1:0]             cfg_data = '0;

    vertex_scoreboard sb = new();
    int  idle_cycles = 0;
    int  burst_left = 0;
    int  free_run = 0;
    int  stall_left = 0;

    always #5 clk = ~clk;

    clip_to_window_transform uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // monitor: every handshake is seen at the rising edge, before updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_vertex(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_window(m_tdata);
        end
    end

    // watchdog: too long without any beat moving on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // receiver: free-running stretches, long stalls and random chatter
    always @(negedge clk)
    begin
        if (free_run > 0)
        begin
            free_run--;
            m_tready = 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready = 1'b0;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0:       free_run = $urandom_range(20, 120);
                1, 2:    stall_left = $urandom_range(1, 20);
                default: ;
            endcase
            m_tready = ($urandom_range(0, 3) != 0);
        end
    end

    // one vertex beat; a gap follows only at the end of a burst
    task send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
        int gap;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {w, z, y, x};
        do
            @(posedge clk);
        while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 150)
                                                   : $urandom_range(0, 25);
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1)
                    @(negedge clk);
            end
        end
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task set_viewport(logic [31:0] sx, logic [31:0] sy, logic [31:0] ox,
                      logic [31:0] oy, logic [31:0] df, logic [31:0] db);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_DEPTH_FACTOR, df);
        write_reg(REG_DEPTH_BASE, db);
    endtask

    // registers change only with the pipe empty
    task drain;
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.window_q.size() != 0)
            @(negedge clk);
    endtask

    // w spread over the zero, tiny, small, boundary and large ranges
    function logic signed [31:0] pick_w();
        case ($urandom_range(0, 11))
            0:       return $urandom_range(0, 4) - 2;
            1:       return $urandom_range(0, 1) ? 32'sh0100_0000 : 32'sh00ff_ffff;
            2:       return $urandom_range(0, 1) ? -32'sh0100_0000 : -32'sh0100_0001;
            3, 4:    return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
            5, 6:    return $signed($urandom_range(1, 32'h0003_ffff));
            7:       return -$signed($urandom_range(1, 32'h0003_ffff));
            default: return $urandom();
        endcase
    endfunction

    // coordinate inside, on or beyond the clip bounds
    function logic signed [31:0] pick_coord(logic signed [31:0] w);
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return -w;
            2:       return w - 1;
            3:       return w + $signed($urandom_range(0, 4));
            4:       return -w - $signed($urandom_range(1, 4));
            default: return (w == 0) ? $signed($urandom())
                                     : $signed($urandom()) % w;
        endcase
    endfunction

    task random_vertices(int n);
        logic signed [31:0] w;
        repeat (n)
        begin
            w = pick_w();
            send_vertex(pick_coord(w), pick_coord(w), pick_coord(w), w);
        end
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // registers still at reset: window x, y and depth reduce to zero terms
        send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0004_0000);
        drain();

        // directed: a typical viewport through the special cases
        set_viewport(32'h0140_0000, 32'h00f0_0000, 32'h0140_0000, 32'h00f0_0000,
                     32'h7fff_0000, 32'h0000_8000);
        send_vertex(32'h0, 32'h0, 32'h0, 32'h0);                       // zero w
        send_vertex(32'h0000_8000, 32'hffff_0000, 32'h0, 32'h1);       // w = 1
        send_vertex(32'h0, 32'h0, 32'h0, 32'hffff_ffff);               // w = -1
        send_vertex(32'h1, 32'h0, 32'h1, 32'h2);                       // w = 2
        send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
        send_vertex(32'h0000_ffff, 32'hffff_0000, 32'h0000_ffff, 32'h0001_0000);
        // negative w: both clamps fire, the upper one wins
        send_vertex(32'h0, 32'h0005_0000, 32'hfff0_0000, 32'hfffe_0000);
        send_vertex(32'h00ff_fffe, 32'hff00_0001, 32'h0, 32'h00ff_ffff);   // last small
        send_vertex(32'h00ff_ffff, 32'hff00_0000, 32'h0080_0000, 32'h0100_0000);
        send_vertex(32'h0, 32'h0100_0000, 32'hff00_0000, 32'hff00_0000);   // -2^24, small
        send_vertex(32'h0100_0000, 32'h0, 32'h0, 32'hfeff_ffff);          // first large neg
        send_vertex(32'h7fff_fffe, 32'h8000_0001, 32'h4000_0000, 32'h7fff_ffff);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000);
        send_vertex(32'h0000_0800, 32'h0000_07ff, 32'h0, 32'h0001_0000);  // rounding edge
        send_vertex(32'h0003_0000, 32'hfffd_0000, 32'h0003_0000, 32'h0003_0000);
        random_vertices(250);
        drain();

        // extremes: all registers at the positive limit
        set_viewport(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h7fff_ffff);
        random_vertices(250);
        drain();

        // extremes: all registers at the negative limit
        set_viewport(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000);
        random_vertices(250);
        drain();

        // depth range small enough that the clamp is rarely hit
        set_viewport(32'hfec0_0000, 32'h0100_0000, 32'h0, 32'hffff_0000,
                     32'h0000_8000, 32'h0000_8000);
        random_vertices(250);
        drain();

        set_viewport($urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom());
        random_vertices(330);
        drain();

        repeat (50)
            @(posedge clk);
        if (sb.errors == 0 && sb.window_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
